// File: rtl/core/mwsu_pkg.sv
// Package: shared types, constants and the exp lookup table for the weighted sequence update.
`default_nettype none
package mwsu_pkg;

  localparam int unsigned MaxSamples = 128;
  localparam int unsigned MaxSteps   = 8;
  localparam int unsigned ExpDepth   = 256;
  localparam int unsigned SampleW    = $clog2(MaxSamples);
  localparam int unsigned SumW       = 40;
  localparam int unsigned WeightW    = 17;
  localparam int unsigned NumW       = 33;
  localparam int unsigned DenW       = 24;
  localparam int unsigned CfgW       = 24;

  localparam logic [63:0] ExpStepQ32 = 64'd4034748382;

  // Configuration register indexes
  localparam logic [2:0] CFG_INV_TEMP   = 3'd0;
  localparam logic [2:0] CFG_ACCEL_LOW  = 3'd1;
  localparam logic [2:0] CFG_ACCEL_HIGH = 3'd2;
  localparam logic [2:0] CFG_WIDTH_HIGH = 3'd3;
  localparam logic [2:0] CFG_ANGLE_LIM  = 3'd4;
  localparam logic [2:0] CFG_STEPS      = 3'd5;
  localparam logic [2:0] CFG_SAMPLES    = 3'd6;

  localparam logic FUNC_COST = 1'b0;
  localparam logic FUNC_ROW  = 1'b1;

  typedef struct packed {
    logic              func;
    logic [6:0]        sample_index;
    logic [2:0]        step_index;
    logic [31:0]       cost_value;
    logic              cost_finite;
    logic signed [15:0] ctrl_accel;
    logic signed [15:0] ctrl_width;
    logic signed [15:0] ctrl_angle;
    logic              last_item;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         out_step;
    logic signed [15:0] mean_accel;
    logic signed [15:0] mean_width;
    logic signed [15:0] mean_angle;
    logic               uniform_used;
    logic               last_row;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_COSTS,
    ST_MIN_RD,
    ST_MIN_CMP,
    ST_EXP_RD,
    ST_EXP_MUL,
    ST_EXP_WR,
    ST_NORM_RD,
    ST_NORM_DIV,
    ST_NORM_WAIT,
    ST_UNI_DIV,
    ST_UNI_WAIT,
    ST_ROWS,
    ST_MAC,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [NumW-1:0] quo;
  } div_rsp_t;

  typedef logic [WeightW-1:0] exp_tab_t [ExpDepth];

  // exp(-i/16) in Q1.16, by repeated multiplication with exp(-1/16) in Q0.32
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t     t;
    logic [127:0] v;
    v = 128'd1 << 32;
    for (int i = 0; i < int'(ExpDepth); i++) begin
      t[i] = WeightW'((v + 128'd32768) >> 16);
      v = ((v * {64'd0, ExpStepQ32}) + 128'h8000_0000) >> 32;
    end
    return t;
  endfunction

  localparam exp_tab_t ExpTab = build_exp_tab();

endpackage
`default_nettype wire

// File: rtl/core/mwsu_if.sv
// Interfaces: valid/ready channels for input items and result rows.
`default_nettype none
interface mwsu_in_if;
  logic               valid;
  logic               ready;
  mwsu_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mwsu_out_if;
  logic                valid;
  logic                ready;
  mwsu_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/mppi_weighted_sequence_update.sv
// Top level: softmin-weighted mean of sampled control sequences.
//
// Usage. Items enter on in_i (valid/ready); a transaction is accepted when both are high.
// A batch is: cost items (func 0), one per sample, the last one marked last_item; then
// control rows (func 1) per sample and step, the last one marked last_item. The last row
// makes the block emit one mean row per horizon step on out_o, step 0 first, last_row on
// the final one. Items of the wrong kind for the current phase are accepted and dropped.
// Cost items are taken whenever valid in the cost phase. The last cost starts a weight
// pass that reads the cost memory once per sample for the minimum and, if any cost is
// finite, once more for the exp weights, then normalizes each weight through the shared
// restoring divider; with no finite cost it instead takes one uniform weight from it.
// in_i.ready is low during the pass. A control row is a weight memory read, then one
// multiply-accumulate per control value through a single multiplier. Emission moves on
// one step each time the output register is free. A stalled receiver holds the output
// register and the sequencer waits on it. Reset clears the batch: no finite marks, zero
// sums, cost phase; configuration registers take their documented reset values. Write
// configuration only while the block is idle.
`default_nettype none
module mppi_weighted_sequence_update (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  mwsu_in_if.sink          in_i,
  mwsu_out_if.source       out_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [mwsu_pkg::CfgW-1:0] cfg_data_i
);
  localparam int unsigned SW  = mwsu_pkg::SampleW;
  localparam int unsigned KW  = SW + 1;
  localparam int unsigned WW  = mwsu_pkg::WeightW;
  localparam int unsigned SMW = mwsu_pkg::SumW;
  localparam int unsigned NSum = mwsu_pkg::MaxSteps * 3;

  localparam logic signed [SMW-1:0] SumMax = {1'b0, {(SMW-1){1'b1}}};
  localparam logic signed [SMW-1:0] SumMin = {1'b1, {(SMW-1){1'b0}}};

  // configuration
  logic [23:0] inv_temp_q;
  logic [14:0] accel_lo_q, accel_hi_q, width_hi_q, angle_lim_q;
  logic [3:0]  steps_q;
  logic [7:0]  samples_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_temp_q  <= 24'd655360;
      accel_lo_q  <= 15'd205;
      accel_hi_q  <= 15'd1638;
      width_hi_q  <= 15'd614;
      angle_lim_q <= 15'd2145;
      steps_q     <= 4'd6;
      samples_q   <= 8'd100;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mwsu_pkg::CFG_INV_TEMP:   inv_temp_q  <= cfg_data_i;
        mwsu_pkg::CFG_ACCEL_LOW:  accel_lo_q  <= cfg_data_i[14:0];
        mwsu_pkg::CFG_ACCEL_HIGH: accel_hi_q  <= cfg_data_i[14:0];
        mwsu_pkg::CFG_WIDTH_HIGH: width_hi_q  <= cfg_data_i[14:0];
        mwsu_pkg::CFG_ANGLE_LIM:  angle_lim_q <= cfg_data_i[14:0];
        mwsu_pkg::CFG_STEPS:      steps_q     <= cfg_data_i[3:0];
        mwsu_pkg::CFG_SAMPLES:    samples_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // bounded counts: zero acts as one, large values as the maximum
  logic [3:0]    n_steps;
  logic [KW-1:0] n_samples;
  always_comb begin
    if (steps_q == 4'd0) n_steps = 4'd1;
    else if (steps_q > 4'(mwsu_pkg::MaxSteps)) n_steps = 4'(mwsu_pkg::MaxSteps);
    else n_steps = steps_q;
    if (samples_q == 8'd0) n_samples = KW'(1);
    else if ({1'b0, samples_q} > 9'(mwsu_pkg::MaxSamples)) n_samples = KW'(mwsu_pkg::MaxSamples);
    else n_samples = KW'(samples_q);
  end

  // state
  mwsu_pkg::state_e state_q, state_d;
  logic [KW-1:0]    idx_q;
  logic [1:0]       comp_q;
  logic [3:0]       emit_q;
  logic             any_q;
  logic [31:0]      least_q;
  logic [mwsu_pkg::DenW-1:0] total_q;
  logic             uniform_q;
  logic [WW-1:0]    uni_w_q;
  logic [mwsu_pkg::MaxSamples-1:0] finite_q;
  logic signed [SMW-1:0] sums_q [NSum];
  logic [55:0]      prod_q;

  // latched row
  logic [2:0]         row_step_q;
  logic signed [15:0] row_ctrl_q [3];
  logic               row_last_q;
  logic               row_use_q;

  // memories
  logic [31:0]   cost_mem [mwsu_pkg::MaxSamples];
  logic [WW-1:0] w_mem [mwsu_pkg::MaxSamples];
  logic [31:0]   cost_rd_q;
  logic [WW-1:0] w_rd_q;

  // output register
  logic                out_valid_q;
  mwsu_pkg::out_item_t out_q;

  mwsu_pkg::div_req_t div_req;
  mwsu_pkg::div_rsp_t div_rsp;

  mwsu_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic accept;
  logic idx_end;
  logic out_free;
  logic emit_last;
  assign accept    = in_i.valid && in_i.ready;
  assign idx_end   = (idx_q == n_samples);
  assign out_free  = !out_valid_q || out_o.ready;
  assign emit_last = (emit_q + 4'd1 == n_steps);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mwsu_pkg::ST_COSTS:
        if (accept && in_i.data.func == mwsu_pkg::FUNC_COST && in_i.data.last_item)
          state_d = mwsu_pkg::ST_MIN_RD;
      mwsu_pkg::ST_MIN_RD:
        if (!idx_end) state_d = mwsu_pkg::ST_MIN_CMP;
        else if (any_q) state_d = mwsu_pkg::ST_EXP_RD;
        else state_d = mwsu_pkg::ST_UNI_DIV;
      mwsu_pkg::ST_MIN_CMP:  state_d = mwsu_pkg::ST_MIN_RD;
      mwsu_pkg::ST_EXP_RD:
        state_d = idx_end ? mwsu_pkg::ST_NORM_RD : mwsu_pkg::ST_EXP_MUL;
      mwsu_pkg::ST_EXP_MUL:  state_d = mwsu_pkg::ST_EXP_WR;
      mwsu_pkg::ST_EXP_WR:   state_d = mwsu_pkg::ST_EXP_RD;
      mwsu_pkg::ST_NORM_RD:
        state_d = idx_end ? mwsu_pkg::ST_ROWS : mwsu_pkg::ST_NORM_DIV;
      mwsu_pkg::ST_NORM_DIV: state_d = mwsu_pkg::ST_NORM_WAIT;
      mwsu_pkg::ST_NORM_WAIT:
        if (div_rsp.done) state_d = mwsu_pkg::ST_NORM_RD;
      mwsu_pkg::ST_UNI_DIV:  state_d = mwsu_pkg::ST_UNI_WAIT;
      mwsu_pkg::ST_UNI_WAIT:
        if (div_rsp.done) state_d = mwsu_pkg::ST_ROWS;
      mwsu_pkg::ST_ROWS:
        if (accept && in_i.data.func == mwsu_pkg::FUNC_ROW) state_d = mwsu_pkg::ST_MAC;
      mwsu_pkg::ST_MAC:
        if (comp_q == 2'd2) state_d = row_last_q ? mwsu_pkg::ST_EMIT : mwsu_pkg::ST_ROWS;
      mwsu_pkg::ST_EMIT:
        if (out_free && emit_last) state_d = mwsu_pkg::ST_COSTS;
      default: state_d = mwsu_pkg::ST_COSTS;
    endcase
  end

  // control outputs
  logic [SW-1:0] w_raddr;
  logic          w_rd_en;
  logic          w_we;
  logic [WW-1:0] w_wdata;
  logic [WW-1:0] exp_w;

  always_comb begin
    in_i.ready    = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    w_raddr       = idx_q[SW-1:0];
    w_rd_en       = 1'b0;
    w_we          = 1'b0;
    w_wdata       = '0;
    // raw weight: table entry while the sample is finite and the index stays inside the table, else zero
    if (!finite_q[idx_q[SW-1:0]] || prod_q[55:36] != '0) exp_w = '0;
    else exp_w = mwsu_pkg::ExpTab[prod_q[35:28]];
    unique case (state_q)
      mwsu_pkg::ST_COSTS: in_i.ready = 1'b1;
      mwsu_pkg::ST_ROWS: begin
        in_i.ready = 1'b1;
        w_raddr    = in_i.data.sample_index[SW-1:0];
        w_rd_en    = accept;
      end
      mwsu_pkg::ST_EXP_WR: begin
        w_we    = 1'b1;
        w_wdata = exp_w;
      end
      mwsu_pkg::ST_NORM_RD: w_rd_en = !idx_end;
      mwsu_pkg::ST_NORM_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = {w_rd_q[15:0] == '0 && w_rd_q[16], 16'd0, 16'd0}
                        | ({w_rd_q, 16'd0} + mwsu_pkg::NumW'(total_q >> 1));
        div_req.den   = total_q;
      end
      mwsu_pkg::ST_NORM_WAIT: begin
        w_we    = div_rsp.done;
        w_wdata = div_rsp.quo[WW-1:0];
      end
      mwsu_pkg::ST_UNI_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = mwsu_pkg::NumW'(65536) + mwsu_pkg::NumW'(n_samples >> 1);
        div_req.den   = mwsu_pkg::DenW'(n_samples);
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (state_q == mwsu_pkg::ST_COSTS && accept && in_i.data.func == mwsu_pkg::FUNC_COST)
      cost_mem[in_i.data.sample_index[SW-1:0]] <= in_i.data.cost_value;
    if (state_q == mwsu_pkg::ST_MIN_RD || state_q == mwsu_pkg::ST_EXP_RD)
      cost_rd_q <= cost_mem[idx_q[SW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (w_we) w_mem[idx_q[SW-1:0]] <= w_wdata;
    if (w_rd_en) w_rd_q <= w_mem[w_raddr];
  end

  // multiply-accumulate for one control value
  logic [4:0]             sum_idx;
  logic [WW-1:0]          mac_w;
  logic signed [WW+16:0]  mac_prod;
  logic signed [SMW:0]    mac_sum;
  logic signed [SMW-1:0]  mac_sat;
  assign sum_idx  = 5'(row_step_q) * 5'd3 + 5'(comp_q);
  assign mac_w    = uniform_q ? uni_w_q : w_rd_q;
  assign mac_prod = $signed({1'b0, mac_w}) * row_ctrl_q[comp_q];
  assign mac_sum  = {sums_q[sum_idx][SMW-1], sums_q[sum_idx]} + (SMW+1)'(mac_prod);
  always_comb begin
    if (mac_sum > (SMW+1)'(SumMax)) mac_sat = SumMax;
    else if (mac_sum < $signed({1'b1, SumMin})) mac_sat = SumMin;
    else mac_sat = mac_sum[SMW-1:0];
  end

  // rounding and clamping of one emitted row
  logic signed [SMW:0]  rnd [3];
  logic signed [24:0]   mv  [3];
  logic signed [24:0]   ma, mw, mp;
  logic signed [24:0]   a_lo, a_hi, w_hi, p_lim;
  logic [4:0]           emit_base;
  assign emit_base = 5'(emit_q[2:0]) * 5'd3;
  assign a_lo  = $signed({10'd0, accel_lo_q});
  assign a_hi  = $signed({10'd0, accel_hi_q});
  assign w_hi  = $signed({10'd0, width_hi_q});
  assign p_lim = $signed({10'd0, angle_lim_q});
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rnd[c] = {sums_q[emit_base + 5'(c)][SMW-1], sums_q[emit_base + 5'(c)]}
               + (SMW+1)'(32768);
      mv[c]  = rnd[c][SMW:16];
    end
    ma = mv[0];
    if (ma > a_hi) ma = a_hi;
    if (ma < a_lo) ma = a_lo;
    mw = mv[1];
    if (mw > w_hi) mw = w_hi;
    if (mw < 25'sd0) mw = 25'sd0;
    mp = mv[2];
    if (mp > p_lim) mp = p_lim;
    if (mp < -p_lim) mp = -p_lim;
  end

  // control and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mwsu_pkg::ST_COSTS;
      idx_q       <= '0;
      comp_q      <= '0;
      emit_q      <= '0;
      any_q       <= 1'b0;
      least_q     <= '1;
      total_q     <= '0;
      uniform_q   <= 1'b0;
      finite_q    <= '0;
      out_valid_q <= 1'b0;
      for (int s = 0; s < int'(NSum); s++) sums_q[s] <= '0;
    end else begin
      state_q <= state_d;
      // load a row while the register is free, drop it once taken
      if (state_q == mwsu_pkg::ST_EMIT && out_free) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        mwsu_pkg::ST_COSTS:
          if (accept && in_i.data.func == mwsu_pkg::FUNC_COST) begin
            finite_q[in_i.data.sample_index[SW-1:0]] <= in_i.data.cost_finite;
            idx_q   <= '0;
            any_q   <= 1'b0;
            least_q <= '1;
          end
        mwsu_pkg::ST_MIN_RD:
          if (idx_end) begin
            idx_q   <= '0;
            total_q <= '0;
          end
        mwsu_pkg::ST_MIN_CMP: begin
          if (finite_q[idx_q[SW-1:0]]) begin
            any_q <= 1'b1;
            if (!any_q || cost_rd_q < least_q) least_q <= cost_rd_q;
          end
          idx_q <= idx_q + 1'b1;
        end
        mwsu_pkg::ST_EXP_RD:
          if (idx_end) idx_q <= '0;
        mwsu_pkg::ST_EXP_MUL:
          prod_q <= {24'd0, cost_rd_q - least_q} * {32'd0, inv_temp_q};
        mwsu_pkg::ST_EXP_WR: begin
          total_q <= total_q + mwsu_pkg::DenW'(exp_w);
          idx_q   <= idx_q + 1'b1;
        end
        mwsu_pkg::ST_NORM_RD:
          if (idx_end) uniform_q <= 1'b0;
        mwsu_pkg::ST_NORM_WAIT:
          if (div_rsp.done) idx_q <= idx_q + 1'b1;
        mwsu_pkg::ST_UNI_WAIT:
          if (div_rsp.done) begin
            uni_w_q   <= div_rsp.quo[WW-1:0];
            uniform_q <= 1'b1;
          end
        mwsu_pkg::ST_ROWS:
          if (accept && in_i.data.func == mwsu_pkg::FUNC_ROW) begin
            row_step_q    <= in_i.data.step_index;
            row_ctrl_q[0] <= in_i.data.ctrl_accel;
            row_ctrl_q[1] <= in_i.data.ctrl_width;
            row_ctrl_q[2] <= in_i.data.ctrl_angle;
            row_last_q    <= in_i.data.last_item;
            row_use_q     <= (KW'(in_i.data.sample_index) < n_samples)
                             && (4'(in_i.data.step_index) < n_steps);
            comp_q        <= '0;
          end
        mwsu_pkg::ST_MAC: begin
          if (row_use_q) sums_q[sum_idx] <= mac_sat;
          comp_q <= comp_q + 2'd1;
          emit_q <= '0;
        end
        mwsu_pkg::ST_EMIT:
          if (out_free) begin
            out_q.out_step     <= emit_q[2:0];
            out_q.mean_accel   <= ma[15:0];
            out_q.mean_width   <= mw[15:0];
            out_q.mean_angle   <= mp[15:0];
            out_q.uniform_used <= uniform_q;
            out_q.last_row     <= emit_last;
            emit_q             <= emit_q + 4'd1;
            if (emit_last) begin
              // start a new batch
              finite_q <= '0;
              least_q  <= '1;
              total_q  <= '0;
              for (int s = 0; s < int'(NSum); s++) sums_q[s] <= '0;
            end
          end
        default: ;
      endcase
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;
endmodule
`default_nettype wire

// File: rtl/core/mwsu_div.sv
// Restoring divider: one quotient bit per cycle, shared by weight normalization and the uniform weight.
`default_nettype none
module mwsu_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mwsu_pkg::div_req_t req_i,
  output mwsu_pkg::div_rsp_t      rsp_o
);
  localparam int unsigned CntW = $clog2(mwsu_pkg::NumW + 1);

  logic                          busy_q, busy_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [mwsu_pkg::DenW-1:0]     rem_q, rem_d;
  logic [mwsu_pkg::NumW-1:0]     quo_q, quo_d;
  logic [mwsu_pkg::DenW-1:0]     den_q, den_d;
  logic                          done_q, done_d;
  logic [mwsu_pkg::DenW:0]       trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[mwsu_pkg::NumW-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.num;
      den_d  = req_i.den;
    end else if (busy_q) begin
      // shift in one dividend bit, subtract where it fits
      if (trial >= {1'b0, den_q}) begin
        rem_d = mwsu_pkg::DenW'(trial - {1'b0, den_q});
        quo_d = {quo_q[mwsu_pkg::NumW-2:0], 1'b1};
      end else begin
        rem_d = trial[mwsu_pkg::DenW-1:0];
        quo_d = {quo_q[mwsu_pkg::NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(mwsu_pkg::NumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
endmodule
`default_nettype wire
